// ===== src/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the range majority query engine.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int CAPACITY = 1024;
	localparam int POS_W    = 11;
	localparam int VAL_W    = 11;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int NODE_W   = IDX_W + 1;
	localparam int CNT_W    = IDX_W + 1;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_RECALL = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [VAL_W-1:0] cand;
		logic [CNT_W-1:0] cnt;
	} vote_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_LEAF,
		ST_WR_READ,
		ST_WR_MERGE,
		ST_Q_STEP,
		ST_Q_WAIT,
		ST_Q_MERGE,
		ST_C_READ,
		ST_C_LAST,
		ST_DONE
	} state_t;

	function automatic vote_t vote_merge(input vote_t a, input vote_t b);
		vote_t r;
		if (a.cand == b.cand) begin
			r.cand = a.cand;
			r.cnt  = a.cnt + b.cnt;
		end else if (a.cnt > b.cnt) begin
			r.cand = a.cand;
			r.cnt  = a.cnt - b.cnt;
		end else begin
			r.cand = b.cand;
			r.cnt  = b.cnt - a.cnt;
		end
		return r;
	endfunction

endpackage

// ===== src/range_majority_query_engine.sv =====
// ----------------------------------------------------------------------------
// range_majority_query_engine
// Segment tree of Boyer-Moore votes with a value store and range queries.
// ----------------------------------------------------------------------------
// A write stores the leaf and the value, then for each tree level reads both
// children and writes their merged vote to the parent. A query merges the
// covering nodes, then reads each position of the range and counts matches.
// One request at a time; the next is accepted once the answer has left.
// After reset a clearing pass writes every tree node and value slot.
// ----------------------------------------------------------------------------
module range_majority_query_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[1:0], left_position[12:2], right_position[23:13],
	// write_value[34:24], fallback_value[45:35]
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// answer_value[10:0], majority_found[11]
	output logic [15:0] m_tdata
);

	localparam int IW = rmq_pkg::IDX_W;
	localparam int NW = rmq_pkg::NODE_W;
	localparam int VW = rmq_pkg::VAL_W;
	localparam int CW = rmq_pkg::CNT_W;

	rmq_pkg::state_t state_q, state_d;

	rmq_pkg::vote_t tree_mem [2*rmq_pkg::CAPACITY];
	logic [VW-1:0]  val_mem  [rmq_pkg::CAPACITY];

	logic           t_we;
	logic [NW-1:0]  t_waddr, t_raddr;
	rmq_pkg::vote_t t_wdata, t_rdata;
	logic           v_we;
	logic [IW-1:0]  v_waddr, v_raddr;
	logic [VW-1:0]  v_wdata, v_rdata;

	always_ff @(posedge clk) begin
		if (t_we) tree_mem[t_waddr] <= t_wdata;
		t_rdata <= tree_mem[t_raddr];
		if (v_we) val_mem[v_waddr] <= v_wdata;
		v_rdata <= val_mem[v_raddr];
	end

	logic [1:0]     mode_q;
	logic [VW-1:0]  fall_q, last_q, ans_q;
	logic           found_q;
	logic [NW-1:0]  clr_q;
	logic [CW-1:0]  clr_cnt_q;
	logic [NW:0]    lo_q, hi_q;
	logic [NW-1:0]  node_q;
	rmq_pkg::vote_t left_q, accl_q, accr_q, tot_q;
	logic           rd_hi_q, lo_pend_q, hi_pend_q;
	logic [IW-1:0]  cpos_q, cend_q;
	logic [CW-1:0]  hits_q, len_q;
	logic           out_v_q;
	logic           c_v_s1;
	logic           maj;

	logic [1:0]    in_mode;
	logic [10:0]   in_left, in_right, in_wval, in_fall;
	assign in_mode  = s_tdata[1:0];
	assign in_left  = s_tdata[12:2];
	assign in_right = s_tdata[23:13];
	assign in_wval  = s_tdata[34:24];
	assign in_fall  = s_tdata[45:35];

	logic acc;
	assign s_tready = (state_q == rmq_pkg::ST_IDLE) && !out_v_q;
	assign acc = s_tvalid && s_tready;

	logic [11:0] qleft, qright;
	always_comb begin
		qleft  = (in_left == 11'd0) ? 12'd1 : {1'b0, in_left};
		qright = ({1'b0, in_right} > 12'(rmq_pkg::CAPACITY)) ?
			12'(rmq_pkg::CAPACITY) : {1'b0, in_right};
	end

	logic wr_ok, q_ok;
	assign wr_ok = (in_left != 11'd0) && ({1'b0, in_left} <= 12'(rmq_pkg::CAPACITY));
	assign q_ok  = qleft <= qright;

	assign maj = (len_q != '0) && ({hits_q, 1'b0} > {1'b0, len_q});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rmq_pkg::ST_CLEAR:
				if (clr_q == NW'(1)) state_d = rmq_pkg::ST_IDLE;
			rmq_pkg::ST_IDLE:
				if (acc) begin
					if ((in_mode == rmq_pkg::MODE_WRITE || in_mode == rmq_pkg::MODE_RECALL)
						&& wr_ok) state_d = rmq_pkg::ST_WR_LEAF;
					else if (in_mode == rmq_pkg::MODE_QUERY)
						state_d = q_ok ? rmq_pkg::ST_Q_STEP : rmq_pkg::ST_DONE;
				end
			rmq_pkg::ST_WR_LEAF:
				state_d = rmq_pkg::ST_WR_READ;
			rmq_pkg::ST_WR_READ:
				state_d = rd_hi_q ? rmq_pkg::ST_WR_MERGE : rmq_pkg::ST_WR_READ;
			rmq_pkg::ST_WR_MERGE:
				state_d = (node_q == NW'(1)) ? rmq_pkg::ST_IDLE : rmq_pkg::ST_WR_READ;
			rmq_pkg::ST_Q_STEP:
				if (lo_pend_q || hi_pend_q) state_d = rmq_pkg::ST_Q_WAIT;
				else if (lo_q >= hi_q) state_d = rmq_pkg::ST_Q_MERGE;
			rmq_pkg::ST_Q_WAIT:
				state_d = rmq_pkg::ST_Q_STEP;
			rmq_pkg::ST_Q_MERGE:
				state_d = rmq_pkg::ST_C_READ;
			rmq_pkg::ST_C_READ:
				if (cpos_q == cend_q) state_d = rmq_pkg::ST_C_LAST;
			rmq_pkg::ST_C_LAST:
				state_d = rmq_pkg::ST_DONE;
			rmq_pkg::ST_DONE:
				state_d = rmq_pkg::ST_IDLE;
			default:
				state_d = rmq_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		t_we    = 1'b0;
		t_waddr = node_q;
		t_wdata = '0;
		t_raddr = node_q;
		v_we    = 1'b0;
		v_waddr = cpos_q;
		v_wdata = '0;
		v_raddr = cpos_q;
		case (state_q)
			rmq_pkg::ST_CLEAR: begin
				t_we    = 1'b1;
				t_waddr = clr_q;
				t_wdata = '{cand: '0, cnt: clr_cnt_q};
				v_we    = clr_q[NW-1];
				v_waddr = clr_q[IW-1:0];
			end
			rmq_pkg::ST_WR_LEAF: begin
				t_we    = 1'b1;
				t_waddr = node_q;
				t_wdata = '{cand: (mode_q == rmq_pkg::MODE_WRITE) ? fall_q : last_q,
					cnt: CW'(1)};
				v_we    = 1'b1;
				v_waddr = node_q[IW-1:0];
				v_wdata = t_wdata.cand;
			end
			rmq_pkg::ST_WR_READ:
				t_raddr = {node_q[NW-2:0], rd_hi_q};
			rmq_pkg::ST_WR_MERGE: begin
				t_we    = 1'b1;
				t_waddr = node_q;
				t_wdata = rmq_pkg::vote_merge(left_q, t_rdata);
			end
			rmq_pkg::ST_Q_STEP:
				t_raddr = lo_pend_q ? NW'((lo_q << 1) - 1'b1) : NW'(hi_q << 1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmq_pkg::ST_CLEAR;
			clr_q     <= NW'(2 * rmq_pkg::CAPACITY - 1);
			clr_cnt_q <= CW'(1);
			last_q    <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rmq_pkg::ST_CLEAR) begin
				clr_q <= clr_q - 1'b1;
				if ((clr_q & (clr_q - 1'b1)) == '0)
					clr_cnt_q <= {clr_cnt_q[CW-2:0], 1'b0};
			end
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (state_q == rmq_pkg::ST_DONE) begin
				out_v_q <= 1'b1;
				last_q  <= maj ? tot_q.cand : ans_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_v_s1 <= 1'b0;
		else c_v_s1 <= (state_q == rmq_pkg::ST_C_READ);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rmq_pkg::ST_IDLE:
				if (acc) begin
					mode_q    <= in_mode;
					fall_q    <= (in_mode == rmq_pkg::MODE_WRITE) ? in_wval : in_fall;
					node_q    <= NW'(rmq_pkg::CAPACITY) + NW'(in_left - 11'd1);
					rd_hi_q   <= 1'b0;
					lo_q      <= (NW+1)'(rmq_pkg::CAPACITY) + (NW+1)'(qleft - 12'd1);
					hi_q      <= (NW+1)'(rmq_pkg::CAPACITY) + (NW+1)'(qright);
					accl_q    <= '0;
					accr_q    <= '0;
					lo_pend_q <= 1'b0;
					hi_pend_q <= 1'b0;
					cpos_q    <= IW'(qleft - 12'd1);
					cend_q    <= IW'(qright - 12'd1);
					len_q     <= CW'(qright - qleft + 12'd1);
					hits_q    <= '0;
					ans_q     <= in_fall;
					found_q   <= 1'b0;
				end
			rmq_pkg::ST_WR_LEAF:
				node_q <= node_q >> 1;
			rmq_pkg::ST_WR_READ: begin
				rd_hi_q <= ~rd_hi_q;
				if (rd_hi_q) left_q <= t_rdata;
			end
			rmq_pkg::ST_WR_MERGE:
				node_q <= node_q >> 1;
			rmq_pkg::ST_Q_STEP:
				if (lo_pend_q) begin
					lo_pend_q <= 1'b0;
					rd_hi_q   <= 1'b0;
				end else if (hi_pend_q) begin
					hi_pend_q <= 1'b0;
					rd_hi_q   <= 1'b1;
				end else if (lo_q < hi_q) begin
					lo_pend_q <= lo_q[0];
					hi_pend_q <= hi_q[0];
					if (lo_q[0]) lo_q <= (lo_q + 1'b1) >> 1;
					else lo_q <= lo_q >> 1;
					if (hi_q[0]) hi_q <= (hi_q - 1'b1) >> 1;
					else hi_q <= hi_q >> 1;
				end
			rmq_pkg::ST_Q_WAIT: ;
			rmq_pkg::ST_Q_MERGE:
				tot_q <= rmq_pkg::vote_merge(accl_q, accr_q);
			rmq_pkg::ST_C_READ:
				cpos_q <= cpos_q + 1'b1;
			rmq_pkg::ST_C_LAST: ;
			rmq_pkg::ST_DONE: ;
			default: ;
		endcase
		if (state_q == rmq_pkg::ST_Q_WAIT) begin
			if (!rd_hi_q) accl_q <= rmq_pkg::vote_merge(accl_q, t_rdata);
			else accr_q <= rmq_pkg::vote_merge(t_rdata, accr_q);
		end
		if (c_v_s1 && v_rdata == tot_q.cand) hits_q <= hits_q + 1'b1;
		if (state_q == rmq_pkg::ST_DONE && maj) begin
			ans_q   <= tot_q.cand;
			found_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, found_q, ans_q};

endmodule

// ===== test/range_majority_query_engine_tb.sv =====
// ----------------------------------------------------------------------------
// range_majority_query_engine_tb
// Drives writes, recalls and range queries into the majority query engine.
// The predictor keeps its own value store and answer register and finds the
// majority of each range by counting. A directed table comes first, then
// random traffic that is mostly writes into small regions followed by queries
// over them. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_majority_query_engine_tb;

	localparam int RUN_LIMIT = 2500000;

	typedef struct packed {
		logic [10:0] answer;
		logic        found;
	} answer_t;

	typedef struct {
		logic [1:0]  mode;
		logic [10:0] lpos;
		logic [10:0] rpos;
		logic [10:0] wval;
		logic [10:0] fval;
		bit          typed;
		answer_t     want;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	logic [10:0] store_model [1:rmq_pkg::CAPACITY];
	logic [10:0] last_model;
	answer_t     answers_due [$];
	int          mismatch_count;
	int          answers_seen;
	int          cycle_count;
	int          requests_sent;
	int          out_wait = 0;
	request_t    directed [$];

	range_majority_query_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Majority by counting; a strict majority is unique, so no tree is needed.
	function automatic answer_t majority_of(input request_t r);
		answer_t a;
		int lo, hi, len;
		int tally [int];
		lo = (r.lpos < 1) ? 1 : r.lpos;
		hi = (r.rpos > rmq_pkg::CAPACITY) ? rmq_pkg::CAPACITY : r.rpos;
		a.answer = r.fval;
		a.found  = 1'b0;
		if (lo <= hi) begin
			len = hi - lo + 1;
			for (int i = lo; i <= hi; i++)
				tally[store_model[i]]++;
			foreach (tally[v]) begin
				if (2 * tally[v] > len) begin
					a.answer = 11'(v);
					a.found  = 1'b1;
				end
			end
		end
		return a;
	endfunction

	function automatic bit apply_request(input request_t r, output answer_t a);
		apply_request = 1'b0;
		case (r.mode)
			rmq_pkg::MODE_WRITE: begin
				if (r.lpos >= 1 && r.lpos <= rmq_pkg::CAPACITY)
					store_model[r.lpos] = r.wval;
			end
			rmq_pkg::MODE_RECALL: begin
				if (r.lpos >= 1 && r.lpos <= rmq_pkg::CAPACITY)
					store_model[r.lpos] = last_model;
			end
			rmq_pkg::MODE_QUERY: begin
				a = majority_of(r);
				last_model = a.answer;
				apply_request = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic request_t mk(input logic [1:0] m, input int l, input int rp,
			input int w, input int f);
		request_t r;
		r.mode = m;
		r.lpos = 11'(l);
		r.rpos = 11'(rp);
		r.wval = 11'(w);
		r.fval = 11'(f);
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic request_t mk_typed(input int l, input int rp, input int f,
			input int ans, input bit fnd);
		request_t r;
		r = mk(rmq_pkg::MODE_QUERY, l, rp, 0, f);
		r.typed = 1'b1;
		r.want.answer = 11'(ans);
		r.want.found = fnd;
		return r;
	endfunction

	task automatic send(input request_t r);
		answer_t a;
		int pause;
		pause = $urandom_range(0, 17);
		if (pause != 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, r.fval, r.wval, r.rpos, r.lpos, r.mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (apply_request(r, a)) begin
			if (r.typed && a != r.want)
				report("table entry", a.answer, r.want.answer);
			answers_due.push_back(r.typed ? r.want : a);
		end
		requests_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				answers_seen++;
				if (answers_due.size() == 0) begin
					report("unexpected answer", m_tdata[10:0], 0);
				end else begin
					answer_t w;
					w = answers_due.pop_front();
					if (m_tdata[10:0] != w.answer)
						report("answer_value", m_tdata[10:0], w.answer);
					if (m_tdata[11] != w.found)
						report("majority_found", m_tdata[11], w.found);
				end
				out_wait = $urandom_range(0, 17);
			end else if (m_tvalid && out_wait != 0) begin
				out_wait--;
			end
			m_tready <= (out_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (cycle_count > RUN_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("range_majority_query_engine_tb: done, errors");
			$finish;
		end
	end

	initial begin
		request_t r;
		int base, span, stuffed;
		bit drained;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		mismatch_count = 0;
		answers_seen = 0;
		cycle_count = 0;
		requests_sent = 0;
		drained = 1'b0;
		last_model = '0;
		for (int i = 1; i <= rmq_pkg::CAPACITY; i++)
			store_model[i] = '0;

		directed.push_back(mk_typed(1, 1024, 1024, 0, 1'b1));
		directed.push_back(mk_typed(0, 2047, 5, 0, 1'b1));
		directed.push_back(mk_typed(9, 3, 1024, 1024, 1'b0));
		directed.push_back(mk_typed(2047, 2047, 0, 0, 1'b0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 1, 0, 1024, 0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 2, 2047, 1024, 2047));
		directed.push_back(mk_typed(1, 3, 7, 1024, 1'b1));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 0, 0, 77, 0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 1025, 0, 77, 0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 2047, 2047, 2047, 2047));
		directed.push_back(mk_typed(1, 2, 3, 1024, 1'b1));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 1024, 0, 1, 0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 1023, 0, 1, 0));
		directed.push_back(mk(rmq_pkg::MODE_QUERY, 1023, 1024, 0, 9));
		directed.push_back(mk(rmq_pkg::MODE_RECALL, 1022, 0, 0, 0));
		directed.push_back(mk(rmq_pkg::MODE_QUERY, 1021, 2047, 0, 9));
		directed.push_back(mk(rmq_pkg::MODE_UNUSED, 5, 5, 33, 33));
		directed.push_back(mk(rmq_pkg::MODE_QUERY, 1, 4, 0, 1024));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 5, 0, 1, 0));
		directed.push_back(mk(rmq_pkg::MODE_WRITE, 6, 0, 2, 0));
		directed.push_back(mk(rmq_pkg::MODE_QUERY, 5, 6, 0, 555));
		directed.push_back(mk(rmq_pkg::MODE_RECALL, 7, 0, 0, 0));
		directed.push_back(mk(rmq_pkg::MODE_QUERY, 4, 7, 0, 11));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send(directed[i]);

		while (requests_sent < 540) begin
			if (!drained && requests_sent > 300) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (answers_due.size() != 0);
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: begin
					r = mk(2'($urandom_range(0, 3)), $urandom_range(0, 2047),
						$urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 2047));
					send(r);
				end
				1: begin
					base = $urandom_range(1, 1024);
					r = mk(rmq_pkg::MODE_QUERY, base,
						base + $urandom_range(0, 1023 - (base % 1024)),
						0, $urandom_range(0, 2047));
					send(r);
				end
				default: begin
					span = $urandom_range(1, 12);
					base = $urandom_range(1, rmq_pkg::CAPACITY - span + 1);
					stuffed = $urandom_range(0, 2047);
					for (int k = 0; k < span; k++) begin
						if ($urandom_range(0, 2) != 0)
							r = mk(rmq_pkg::MODE_WRITE, base + k, $urandom_range(0, 2047),
								stuffed, $urandom_range(0, 2047));
						else if ($urandom_range(0, 1) != 0)
							r = mk(rmq_pkg::MODE_RECALL, base + k, 0,
								$urandom_range(0, 2047), 0);
						else
							r = mk(rmq_pkg::MODE_WRITE, base + k, 0,
								$urandom_range(0, 2047), 0);
						send(r);
					end
					r = mk(rmq_pkg::MODE_QUERY, base - $urandom_range(0, 1),
						base + span - 1 + $urandom_range(0, 1), 0, $urandom_range(0, 2047));
					send(r);
				end
			endcase
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
		repeat (1200) @(posedge clk);
		$display("%0d requests sent, %0d answers checked, mixed writes, recalls and queries",
			requests_sent, answers_seen);
		if (mismatch_count == 0)
			$display("range_majority_query_engine_tb: done, clean");
		else
			$display("range_majority_query_engine_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rmq_pkg.sv
src/range_majority_query_engine.sv
test/range_majority_query_engine_tb.sv
